[src/blk2b_pkg.sv]
// Shared constants, types and helper functions for the BLAKE2b hash engine.
// Used by the interfaces, the buffer RAM, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps

package blk2b_pkg;

	localparam int WORD_W      = 64;
	localparam int CFG_W       = 7;
	localparam int BLOCK_WORDS = 16;
	localparam int CHAIN_WORDS = 8;

	// Initialization vector shared with SHA-512.
	localparam logic [WORD_W-1:0] IV [CHAIN_WORDS] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
		64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	// Fixed part of parameter word 0: fanout 1, depth 1.
	localparam logic [WORD_W-1:0] PARAM_BASE = 64'h0000_0000_0101_0000;

	// Message word schedule for each round.
	localparam logic [3:0] SIGMA [10][16] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		  4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
		'{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
		  4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
		'{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
		  4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
		'{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
		  4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
		'{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
		  4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
		'{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
		  4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
		'{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
		  4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
		'{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
		  4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
		'{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
		  4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
		'{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
		  4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
	};

	// Working vector, sixteen words arranged as four rows of four.
	typedef logic [15:0][WORD_W-1:0] vstate_t;

	function automatic logic [3:0] sigma_idx(input logic [3:0] rnd, input logic [3:0] pos);
		logic [3:0] rr;
		rr = (rnd >= 4'd10) ? rnd - 4'd10 : rnd;
		return SIGMA[rr][pos];
	endfunction

	// Rotates each row left by its own amount: out[row][j] = in[row][j + sh].
	function automatic vstate_t rot_rows(input vstate_t v, input logic [1:0] s0,
			input logic [1:0] s1, input logic [1:0] s2, input logic [1:0] s3);
		vstate_t    res;
		logic [1:0] sh [4];
		logic [1:0] jj;
		sh[0] = s0;
		sh[1] = s1;
		sh[2] = s2;
		sh[3] = s3;
		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < 4; j++) begin
				jj = 2'(j) + sh[k];
				res[4*k+j] = v[4*k+int'(jj)];
			end
		end
		return res;
	endfunction

	// Mask that keeps the low n bytes of a word; n of eight or more keeps all.
	function automatic logic [WORD_W-1:0] byte_mask(input logic [3:0] n);
		logic [WORD_W-1:0] m;
		if (n >= 4'd8) begin
			m = '1;
		end else begin
			m = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
		end
		return m;
	endfunction

endpackage

[src/blk2b_if.sv]
// Handshake interfaces for the message and digest channels of the hash engine.
// Depends on blk2b_pkg for the word width.
`timescale 1ns / 1ps

interface blk2b_msg_if;
	logic                           valid;
	logic                           ready;
	logic [blk2b_pkg::WORD_W-1:0]   message_word;
	logic [3:0]                     bytes_valid;
	logic                           last;

	modport source (output valid, message_word, bytes_valid, last, input ready);
	modport sink (input valid, message_word, bytes_valid, last, output ready);
endinterface

interface blk2b_dig_if;
	logic                           valid;
	logic                           ready;
	logic [blk2b_pkg::WORD_W-1:0]   digest_word;
	logic [3:0]                     digest_word_bytes;
	logic                           last_word;

	modport source (output valid, digest_word, digest_word_bytes, last_word, input ready);
	modport sink (input valid, digest_word, digest_word_bytes, last_word, output ready);
endinterface

[src/blk2b_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Holds the message block of the hash engine; depends on blk2b_pkg for its default sizes.
`timescale 1ns / 1ps

module blk2b_ram #(
	parameter int WIDTH = blk2b_pkg::WORD_W,
	parameter int DEPTH = blk2b_pkg::BLOCK_WORDS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/blake2b_hash.sv]
// BLAKE2b hash engine top level: sequencer, working vector and one shared G step.
// Depends on blk2b_pkg, blk2b_msg_if, blk2b_dig_if and blk2b_ram.
`timescale 1ns / 1ps

// Channel   Dir  Payload                                        Transfer when
// msg       in   message_word, bytes_valid, last                msg.valid & msg.ready
// dig       out  digest_word, digest_word_bytes, last_word      dig.valid & dig.ready
// cfg       in   cfg_index, cfg_data (0: digest_bytes, 1: key)  cfg_we
//
// A message word that completes no block is accepted in S_IDLE, then appended in S_APPEND.
// A block compression steps through S_CNTLO and S_CNTHI for the byte counter, 12
// rounds of eight G functions in phases on the single shared G step, and S_FINISH
// to fold the result into the chain value.
// After the last word the digest words leave one per transfer; dig may stall freely.
// Reset is asynchronous and puts the engine in idle with the default parameter
// word; the message buffer needs no clearing, since unfilled words read as zero.

module blake2b_hash (
	input  logic              clk,
	input  logic              arst_n,
	blk2b_msg_if.sink         msg,
	blk2b_dig_if.source       dig,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [blk2b_pkg::CFG_W-1:0] cfg_data
);

	localparam int W = blk2b_pkg::WORD_W;

	// One-hot sequencer states.
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_APPEND = 7'b0000010,
		S_CNTLO  = 7'b0000100,
		S_CNTHI  = 7'b0001000,
		S_ROUND  = 7'b0010000,
		S_FINISH = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;

	// Source of a message word during compression.
	typedef enum logic [1:0] {
		M_RAM  = 2'd0,
		M_PART = 2'd1,
		M_ZERO = 2'd2
	} msel_t;

	localparam logic REG_DIGEST = 1'b0;
	localparam logic REG_KEY    = 1'b1;

	state_t                st_q;
	logic [6:0]            digest_bytes_q;
	logic [6:0]            key_bytes_q;
	logic                  active_q;
	logic [6:0]            msg_len_q;
	logic [7:0][W-1:0]     chain_q;
	logic [W-1:0]          ctr_lo_q;
	logic [W-1:0]          ctr_hi_q;
	logic                  carry_q;
	logic [7:0]            buffered_q;
	logic [W-1:0]          part_q;
	logic [W-1:0]          hold_word_q;
	logic [3:0]            hold_n_q;
	logic                  hold_last_q;
	logic                  final_q;
	blk2b_pkg::vstate_t    v_q;
	logic [3:0]            rnd_q;
	logic [2:0]            g_q;
	logic [2:0]            ph_q;
	msel_t                 m_sel_q;
	logic [2:0]            out_idx_q;

	// Block buffer RAM.
	logic                  ram_we;
	logic [3:0]            ram_waddr;
	logic [W-1:0]          ram_wdata;
	logic [3:0]            ram_raddr;
	logic [W-1:0]          ram_rdata;

	blk2b_ram #(
		.WIDTH(blk2b_pkg::WORD_W),
		.DEPTH(blk2b_pkg::BLOCK_WORDS)
	) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Byte append: take as many held bytes as fit in the current block.
	logic [7:0]   room;
	logic [3:0]   take;
	logic [W-1:0] masked;
	logic [2*W-1:0] merged;
	logic         entry_full;
	logic [3:0]   left_n;

	always_comb begin
		room       = 8'd128 - buffered_q;
		take       = ({4'b0000, hold_n_q} < room) ? hold_n_q : room[3:0];
		masked     = hold_word_q & blk2b_pkg::byte_mask(take);
		merged     = {{W{1'b0}}, part_q} | ({{W{1'b0}}, masked} << {buffered_q[2:0], 3'b000});
		entry_full = ({2'b00, buffered_q[2:0]} + {1'b0, take}) >= 5'd8;
		left_n     = hold_n_q - take;
	end

	assign ram_we    = (st_q == S_APPEND) && (take != 4'd0) && entry_full;
	assign ram_waddr = buffered_q[6:3];
	assign ram_wdata = merged[W-1:0];

	// Message word fetch: the first operand is addressed in phase zero, the second
	// afterwards; the registered read lands in time for phases one and three.
	assign ram_raddr = blk2b_pkg::sigma_idx(rnd_q, {g_q, (ph_q != 3'd0)});

	msel_t        m_sel_d;
	logic [W-1:0] m_word;

	always_comb begin
		if ({1'b0, ram_raddr} < buffered_q[7:3]) begin
			m_sel_d = M_RAM;
		end else if ({1'b0, ram_raddr} == buffered_q[7:3]) begin
			m_sel_d = M_PART;
		end else begin
			m_sel_d = M_ZERO;
		end
		case (m_sel_q)
			M_RAM:   m_word = ram_rdata;
			M_PART:  m_word = part_q;
			default: m_word = '0;
		endcase
	end

	// Shared G step on column zero of the working vector.
	blk2b_pkg::vstate_t v_step;
	logic [W-1:0]       sum_a;
	logic [W-1:0]       sum_c;
	logic [W-1:0]       x_d;
	logic [W-1:0]       x_b;

	always_comb begin
		v_step = v_q;
		sum_a  = v_q[0] + v_q[4] + m_word;
		sum_c  = v_q[8] + v_q[12];
		x_d    = v_q[12] ^ sum_a;
		x_b    = v_q[4] ^ sum_c;
		case (ph_q)
			3'd0: begin
				if (g_q == 3'd4) begin
					// Line the diagonals up as columns.
					v_step = blk2b_pkg::rot_rows(v_q, 2'd0, 2'd1, 2'd2, 2'd3);
				end
			end
			3'd1: begin
				v_step[0]  = sum_a;
				v_step[12] = {x_d[31:0], x_d[63:32]};
			end
			3'd2: begin
				v_step[8] = sum_c;
				v_step[4] = {x_b[23:0], x_b[63:24]};
			end
			3'd3: begin
				v_step[0]  = sum_a;
				v_step[12] = {x_d[15:0], x_d[63:16]};
			end
			default: begin
				v_step[8] = sum_c;
				v_step[4] = {x_b[62:0], x_b[63]};
				// Bring the next column into place; after the last diagonal also
				// undo the diagonal alignment.
				if (g_q == 3'd7) begin
					v_step = blk2b_pkg::rot_rows(v_step, 2'd1, 2'd0, 2'd3, 2'd2);
				end else begin
					v_step = blk2b_pkg::rot_rows(v_step, 2'd1, 2'd1, 2'd1, 2'd1);
				end
			end
		endcase
	end

	// Parameter word from the registers, clamped to their legal ranges.
	logic [6:0] d_len;
	logic [6:0] k_len;
	logic [W-1:0] ctr_hi_d;

	always_comb begin
		if (digest_bytes_q == 7'd0) begin
			d_len = 7'd1;
		end else if (digest_bytes_q > 7'd64) begin
			d_len = 7'd64;
		end else begin
			d_len = digest_bytes_q;
		end
		k_len    = (key_bytes_q > 7'd64) ? 7'd64 : key_bytes_q;
		ctr_hi_d = ctr_hi_q + {{(W-1){1'b0}}, carry_q};
	end

	// Digest output, truncated to the latched length.
	logic [2:0] out_last_idx;
	logic       out_is_last;
	logic [3:0] out_bytes;
	logic [6:0] len_m1;

	always_comb begin
		len_m1       = msg_len_q - 7'd1;
		out_last_idx = len_m1[5:3];
		out_is_last  = (out_idx_q == out_last_idx);
		if (out_is_last && (msg_len_q[2:0] != 3'd0)) begin
			out_bytes = {1'b0, msg_len_q[2:0]};
		end else begin
			out_bytes = 4'd8;
		end
	end

	assign msg.ready             = (st_q == S_IDLE);
	assign dig.valid             = (st_q == S_OUT);
	assign dig.digest_word       = chain_q[out_idx_q] & blk2b_pkg::byte_mask(out_bytes);
	assign dig.digest_word_bytes = out_bytes;
	assign dig.last_word         = out_is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= S_IDLE;
			digest_bytes_q <= 7'd64;
			key_bytes_q    <= 7'd0;
			active_q       <= 1'b0;
			msg_len_q      <= 7'd64;
			for (int i = 1; i < blk2b_pkg::CHAIN_WORDS; i++) begin
				chain_q[i] <= blk2b_pkg::IV[i];
			end
			chain_q[0]     <= blk2b_pkg::IV[0] ^ blk2b_pkg::PARAM_BASE ^ 64'd64;
			buffered_q     <= '0;
			part_q         <= '0;
			ctr_lo_q       <= '0;
			ctr_hi_q       <= '0;
			carry_q        <= 1'b0;
			final_q        <= 1'b0;
			v_q            <= '0;
			rnd_q          <= '0;
			g_q            <= '0;
			ph_q           <= '0;
			m_sel_q        <= M_ZERO;
			out_idx_q      <= '0;
			hold_word_q    <= '0;
			hold_n_q       <= '0;
			hold_last_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DIGEST: digest_bytes_q <= cfg_data;
					REG_KEY:    key_bytes_q    <= cfg_data;
					default:    ;
				endcase
			end

			unique case (st_q)
				S_IDLE: begin
					if (msg.valid) begin
						hold_word_q <= msg.message_word;
						hold_n_q    <= (msg.bytes_valid > 4'd8) ? 4'd8 : msg.bytes_valid;
						hold_last_q <= msg.last;
						if (!active_q) begin
							// First word of a message: start from the IV.
							active_q   <= 1'b1;
							msg_len_q  <= d_len;
							for (int i = 1; i < blk2b_pkg::CHAIN_WORDS; i++) begin
								chain_q[i] <= blk2b_pkg::IV[i];
							end
							chain_q[0] <= blk2b_pkg::IV[0] ^ blk2b_pkg::PARAM_BASE ^
								{49'd0, k_len, 8'd0} ^ {57'd0, d_len};
							ctr_lo_q   <= '0;
							ctr_hi_q   <= '0;
							buffered_q <= '0;
							part_q     <= '0;
						end
						st_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					if ((buffered_q == 8'd128) && (hold_n_q != 4'd0)) begin
						// A full block is followed by more data: compress it first.
						final_q <= 1'b0;
						st_q    <= S_CNTLO;
					end else begin
						part_q      <= (take != 4'd0 && entry_full) ? merged[2*W-1:W]
							: merged[W-1:0];
						buffered_q  <= buffered_q + {4'd0, take};
						hold_word_q <= hold_word_q >> {take, 3'b000};
						hold_n_q    <= left_n;
						if (left_n != 4'd0) begin
							st_q <= S_APPEND;
						end else if (hold_last_q) begin
							final_q <= 1'b1;
							st_q    <= S_CNTLO;
						end else begin
							st_q <= S_IDLE;
						end
					end
				end
				S_CNTLO: begin
					{carry_q, ctr_lo_q} <= {1'b0, ctr_lo_q} + {57'd0, buffered_q};
					st_q <= S_CNTHI;
				end
				S_CNTHI: begin
					ctr_hi_q <= ctr_hi_d;
					for (int i = 0; i < 8; i++) begin
						v_q[i]     <= chain_q[i];
						v_q[i + 8] <= blk2b_pkg::IV[i];
					end
					v_q[12] <= blk2b_pkg::IV[4] ^ ctr_lo_q;
					v_q[13] <= blk2b_pkg::IV[5] ^ ctr_hi_d;
					v_q[14] <= blk2b_pkg::IV[6] ^ {W{final_q}};
					rnd_q <= '0;
					g_q   <= '0;
					ph_q  <= '0;
					st_q  <= S_ROUND;
				end
				S_ROUND: begin
					v_q     <= v_step;
					m_sel_q <= m_sel_d;
					if (ph_q == 3'd4) begin
						ph_q <= '0;
						g_q  <= g_q + 3'd1;
						if (g_q == 3'd7) begin
							if (rnd_q == 4'd11) begin
								st_q <= S_FINISH;
							end else begin
								rnd_q <= rnd_q + 4'd1;
							end
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				S_FINISH: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] ^ v_q[i] ^ v_q[i + 8];
					end
					buffered_q <= '0;
					part_q     <= '0;
					if (final_q) begin
						active_q  <= 1'b0;
						out_idx_q <= '0;
						st_q      <= S_OUT;
					end else begin
						st_q <= S_APPEND;
					end
				end
				S_OUT: begin
					if (dig.ready) begin
						if (out_is_last) begin
							st_q <= S_IDLE;
						end else begin
							out_idx_q <= out_idx_q + 3'd1;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

[src/blk2b_chk.sv]
// Port-level checker for the BLAKE2b hash engine, bound to the top level.
// Depends on blk2b_pkg and on the channel interfaces of blake2b_hash.
`timescale 1ns / 1ps

module blk2b_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          msg_valid,
	input logic                          msg_ready,
	input logic                          dig_valid,
	input logic                          dig_ready,
	input logic [blk2b_pkg::WORD_W-1:0]  dig_word,
	input logic [3:0]                    dig_bytes,
	input logic                          dig_last
);

	// The engine never takes a word while a digest is on offer.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg_ready && dig_valid))
		else $error("message accepted while digest pending");

	// Every accepted word keeps the engine busy in the cycle after it is taken.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && msg_ready) |=> !msg_ready)
		else $error("ready stayed high after a transfer");

	// A stalled digest word holds.
	a_dig_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && !dig_ready) |=> (dig_valid && $stable(dig_word) &&
			$stable(dig_bytes) && $stable(dig_last)))
		else $error("digest word changed under stall");

	// Only the final digest word may be short.
	a_dig_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> (dig_bytes != 4'd0 && dig_bytes <= 4'd8 &&
			(dig_last || dig_bytes == 4'd8)))
		else $error("bad digest byte count");

	// After the last digest word the engine returns to idle.
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && dig_ready && dig_last) |=> (!dig_valid && msg_ready))
		else $error("engine not idle after digest");

endmodule

bind blake2b_hash blk2b_chk u_blk2b_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.msg_valid(msg.valid),
	.msg_ready(msg.ready),
	.dig_valid(dig.valid),
	.dig_ready(dig.ready),
	.dig_word (dig.digest_word),
	.dig_bytes(dig.digest_word_bytes),
	.dig_last (dig.last_word)
);
